>>> design/nec_ir_frame_decoder_top_macros.svh
// assertion macros for the nec ir frame decoder
`ifndef NEC_IR_FRAME_DECODER_TOP_MACROS_SVH
`define NEC_IR_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define NEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/nec_ir_pkg.sv
// package with opcodes, phase and status codes and defaults of the nec ir frame decoder
package nec_ir_pkg;

  localparam int FRAME_SAMPLES_DEF = 33;

  localparam int DATA_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_PULSE = 2'd0;
  localparam logic [1:0] OP_ARM   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ARMED   = 2'd1;
  localparam logic [1:0] PH_CAPTURE = 2'd2;

  localparam logic [1:0] ST_VALID       = 2'd0;
  localparam logic [1:0] ST_BAD_LEADER  = 2'd1;
  localparam logic [1:0] ST_BAD_INVERSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd2;

  localparam logic [DATA_W-1:0] LEADER_MIN_RST    = 16'd12500;
  localparam logic [DATA_W-1:0] LEADER_MAX_RST    = 16'd14500;
  localparam logic [DATA_W-1:0] ONE_THRESHOLD_RST = 16'd2000;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

endpackage

>>> design/nec_ir_frame_decoder_top.sv
// nec ir frame decoder: input register, one-pass decode, result register
// datapath: an input beat is held in the input register, its result in the result register
// throughput: one beat per cycle; a stalled result holds off intake only once
//   the input register also holds a beat
// reset: synchronous active-low rst_n clears phase, count, held data, ready flag
//   and loads the default leader window and one threshold
`include "nec_ir_frame_decoder_top_macros.svh"

module nec_ir_frame_decoder_top
  import nec_ir_pkg::*;
#(
  parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [15:0]          in_pulse_period,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_read_value,
  output logic                 out_ready_flag,
  output logic                 out_frame_done,
  output logic [1:0]           out_frame_status
);

  localparam int CNT_W = $clog2(FRAME_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_SAMPLES - 1);
  localparam logic [CNT_W-1:0] CNT_LAST_BIT = CNT_W'(32);

  // configuration
  logic [DATA_W-1:0] leader_min_r, leader_max_r, one_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_min_r    <= LEADER_MIN_RST;
      leader_max_r    <= LEADER_MAX_RST;
      one_threshold_r <= ONE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEADER_MIN:    leader_min_r    <= cfg_wdata;
        REG_LEADER_MAX:    leader_max_r    <= cfg_wdata;
        REG_ONE_THRESHOLD: one_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_opcode_r;
  logic [15:0] s1_period_r;
  logic        s2_take;
  logic        s1_fire;

  assign s2_take  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid_r && s2_take;
  assign in_stall = s1_valid_r && !s2_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode_r <= in_opcode;
      s1_period_r <= in_pulse_period;
    end
  end

  // decoder state
  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      leader_r, leader_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic [15:0]      held_r, held_nxt;
  logic             waiting_r, waiting_nxt;

  logic [15:0] read_nxt;
  logic        done_nxt;
  logic [1:0]  status_nxt;
  logic [4:0]  bit_idx;
  logic [7:0]  addr_b, addr_inv_b, cmd_b, cmd_inv_b;

  assign bit_idx    = 5'(cnt_r - CNT_W'(1));
  assign addr_b     = shift_nxt[7:0];
  assign addr_inv_b = shift_nxt[15:8];
  assign cmd_b      = shift_nxt[23:16];
  assign cmd_inv_b  = shift_nxt[31:24];

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    leader_nxt  = leader_r;
    shift_nxt   = shift_r;
    held_nxt    = held_r;
    waiting_nxt = waiting_r;
    read_nxt    = '0;
    done_nxt    = 1'b0;
    status_nxt  = ST_VALID;
    unique case (s1_opcode_r)
      OP_PULSE: begin
        if (phase_r == PH_CAPTURE) begin
          if (cnt_r == '0) begin
            leader_nxt = s1_period_r;
          end else if (cnt_r <= CNT_LAST_BIT) begin
            shift_nxt[bit_idx] = (s1_period_r > one_threshold_r);
          end
          if (cnt_r == CNT_LAST) begin
            cnt_nxt   = '0;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
            if (leader_nxt < leader_min_r || leader_nxt > leader_max_r) begin
              status_nxt = ST_BAD_LEADER;
            end else if ((addr_b ^ addr_inv_b) == BYTE_ONES &&
                         (cmd_b ^ cmd_inv_b) == BYTE_ONES) begin
              held_nxt    = {addr_b, cmd_b};
              waiting_nxt = 1'b1;
              status_nxt  = ST_VALID;
            end else begin
              status_nxt = ST_BAD_INVERSE;
            end
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (phase_r == PH_ARMED) begin
          phase_nxt = PH_CAPTURE;
        end
      end
      OP_ARM: begin
        phase_nxt = PH_ARMED;
        cnt_nxt   = '0;
      end
      OP_READ: begin
        if (waiting_r) begin
          read_nxt    = held_r;
          waiting_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      held_r    <= '0;
      waiting_r <= 1'b0;
    end else if (s1_fire) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      held_r    <= held_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      leader_r <= leader_nxt;
      shift_r  <= shift_nxt;
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_read_value   <= read_nxt;
      out_ready_flag   <= waiting_nxt;
      out_frame_done   <= done_nxt;
      out_frame_status <= status_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `NEC_ASSERT_NOW(a_cnt_only_in_capture, cnt_r != '0, phase_r == PH_CAPTURE,
                  "count outside capture")
  `NEC_ASSERT_NEXT(a_arm_restarts, s1_fire && s1_opcode_r == OP_ARM,
                   phase_r == PH_ARMED && cnt_r == '0, "arm did not restart capture")
  `NEC_ASSERT_NOW(a_good_frame_ready,
                  out_valid && out_frame_done && out_frame_status == ST_VALID,
                  out_ready_flag, "valid frame without ready flag")
  `NEC_ASSERT_NOW(a_done_no_read, out_valid && out_frame_done, out_read_value == '0,
                  "read value on frame beat")
  `NEC_ASSERT_NOW(a_stall_when_full, in_stall, s1_valid_r && out_valid_r,
                  "stall with free stage")

endmodule

>>> dv/nec_ir_frame_decoder_top_test.sv
// self-checking testbench for the nec ir frame decoder with a frame-level scoreboard
module nec_ir_frame_decoder_top_test
  import nec_ir_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]           OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SEG_BEATS = 325;

  typedef struct packed {
    logic [15:0] read_value;
    logic        ready_flag;
    logic        frame_done;
    logic [1:0]  frame_status;
  } ir_result_t;

  class nec_frame_scoreboard;
    logic [15:0] leader_min, leader_max, one_threshold;
    logic [1:0]  phase;
    int unsigned sample_idx;
    logic [15:0] leader;
    logic [31:0] bit_word;
    logic [15:0] held;
    logic        waiting;
    ir_result_t  awaited[$];
    int          failures;

    function new();
      leader_min    = LEADER_MIN_RST;
      leader_max    = LEADER_MAX_RST;
      one_threshold = ONE_THRESHOLD_RST;
      phase         = PH_IDLE;
      sample_idx    = 0;
      leader        = '0;
      bit_word      = '0;
      held          = '0;
      waiting       = 1'b0;
      failures      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_LEADER_MIN:    leader_min = val;
        REG_LEADER_MAX:    leader_max = val;
        REG_ONE_THRESHOLD: one_threshold = val;
        default: ;
      endcase
    endfunction

    function void note_beat(logic [1:0] op, logic [15:0] period);
      ir_result_t  r;
      int unsigned idx;
      logic [7:0]  a, ai, c, ci;
      r = '0;
      case (op)
        OP_PULSE: begin
          if (phase == PH_CAPTURE) begin
            idx = sample_idx;
            if (idx == 0) leader = period;
            else if (idx <= 32) bit_word[idx-1] = (period > one_threshold);
            idx++;
            if (idx >= FRAME_SAMPLES_DEF) begin
              sample_idx = 0;
              phase = PH_IDLE;
              r.frame_done = 1'b1;
              a  = bit_word[7:0];
              ai = bit_word[15:8];
              c  = bit_word[23:16];
              ci = bit_word[31:24];
              if (leader < leader_min || leader > leader_max) begin
                r.frame_status = ST_BAD_LEADER;
              end else if ((a ^ ai) == BYTE_ONES && (c ^ ci) == BYTE_ONES) begin
                held = {a, c};
                waiting = 1'b1;
                r.frame_status = ST_VALID;
              end else begin
                r.frame_status = ST_BAD_INVERSE;
              end
            end else begin
              sample_idx = idx;
            end
          end else if (phase == PH_ARMED) begin
            phase = PH_CAPTURE;
          end
        end
        OP_ARM: begin
          phase = PH_ARMED;
          sample_idx = 0;
        end
        OP_READ: begin
          if (waiting) begin
            r.read_value = held;
            waiting = 1'b0;
          end
        end
        default: ;
      endcase
      r.ready_flag = waiting;
      awaited.push_back(r);
    endfunction

    function void check_beat(ir_result_t got);
      ir_result_t exp;
      if (awaited.size() == 0) begin
        if (failures < 10)
          $display("%0t: unexpected beat: value %h ready %b done %b status %0d",
                   $time, got.read_value, got.ready_flag, got.frame_done,
                   got.frame_status);
        failures++;
        return;
      end
      exp = awaited.pop_front();
      if (got !== exp) begin
        if (failures < 10)
          $display("%0t: mismatch exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                   $time, exp.read_value, exp.ready_flag, exp.frame_done,
                   exp.frame_status, got.read_value, got.ready_flag,
                   got.frame_done, got.frame_status);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_READ;
  logic [15:0]          in_pulse_period = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [15:0]          out_read_value;
  logic                 out_ready_flag;
  logic                 out_frame_done;
  logic [1:0]           out_frame_status;

  nec_frame_scoreboard sb = new();
  int send_idle_pct = 22;
  int recv_idle_pct = 65;
  int hold_request = 0;
  int counted_beats = 0;

  nec_ir_frame_decoder_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_pulse_period  (in_pulse_period),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_ready_flag   (out_ready_flag),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status)
  );

  always #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_beat({out_read_value, out_ready_flag, out_frame_done, out_frame_status});
    end
  end

  task automatic send_beat(logic [1:0] op, logic [15:0] period);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_pulse_period <= period;
    do @(posedge clk); while (in_stall);
    if (!(op == OP_PULSE && sb.phase == PH_IDLE)) counted_beats++;
    sb.note_beat(op, period);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_window(logic [15:0] lo, logic [15:0] hi, logic [15:0] thr);
    write_reg(REG_LEADER_MIN, lo);
    write_reg(REG_LEADER_MAX, hi);
    write_reg(REG_ONE_THRESHOLD, thr);
  endtask

  function automatic logic [15:0] bit_period(logic b);
    logic [15:0] t;
    t = sb.one_threshold;
    if (b) begin
      if (t == 16'hFFFF) return 16'hFFFF;
      case ($urandom_range(0, 3))
        0:       return t + 16'd1;
        1:       return 16'hFFFF;
        default: return 16'($urandom_range(t + 1, 65535));
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return t;
      default: return 16'($urandom_range(0, t));
    endcase
  endfunction

  function automatic logic [15:0] leader_pick(bit good);
    logic [15:0] lo, hi;
    lo = sb.leader_min;
    hi = sb.leader_max;
    if (good && lo <= hi) begin
      case ($urandom_range(0, 3))
        0:       return lo;
        1:       return hi;
        default: return 16'($urandom_range(lo, hi));
      endcase
    end
    if (lo > 0 && $urandom_range(0, 1))
      return $urandom_range(0, 1) ? lo - 16'd1 : 16'($urandom_range(0, lo - 1));
    if (hi < 16'hFFFF)
      return $urandom_range(0, 1) ? hi + 16'd1 : 16'($urandom_range(hi + 1, 65535));
    if (lo > 0) return lo - 16'd1;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] frame_word(bit good);
    logic [7:0] a, ai, c, ci;
    a  = 8'($urandom);
    c  = 8'($urandom);
    ai = ~a;
    ci = ~c;
    if (!good) begin
      if ($urandom_range(0, 1)) ai ^= 8'(1 << $urandom_range(0, 7));
      else ci ^= 8'(1 << $urandom_range(0, 7));
    end
    return {ci, c, ai, a};
  endfunction

  // arm, discarded period, leader, 32 bit periods; cut >= 0 re-arms mid frame
  task automatic send_frame(logic [15:0] leader, logic [31:0] word, int cut);
    int i;
    send_beat(OP_ARM, 16'($urandom));
    send_beat(OP_PULSE, 16'($urandom));
    for (i = 0; i < FRAME_SAMPLES_DEF; i++) begin
      if (i == cut) begin
        send_beat(OP_ARM, 16'($urandom));
        return;
      end
      if ($urandom_range(0, 19) == 0)
        send_beat($urandom_range(0, 1) ? OP_READ : OP_SPARE, 16'($urandom));
      if (i == 0) send_beat(OP_PULSE, leader);
      else send_beat(OP_PULSE, bit_period(word[i-1]));
    end
  endtask

  task automatic random_item();
    int n;
    if ($urandom_range(0, 99) < 75) begin
      send_frame(leader_pick($urandom_range(0, 99) < 80),
                 frame_word($urandom_range(0, 99) < 80),
                 ($urandom_range(0, 99) < 10) ? int'($urandom_range(0, 32)) : -1);
      if ($urandom_range(0, 99) < 70) send_beat(OP_READ, 16'($urandom));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) send_beat(2'($urandom_range(0, 3)), 16'($urandom));
    end
  endtask

  initial begin
    int seg, target;
    logic [15:0] lo;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(OP_READ, 16'hFFFF);
    send_beat(OP_SPARE, 16'hFFFF);
    send_beat(OP_PULSE, 16'h0000);
    send_beat(OP_PULSE, 16'hFFFF);
    send_beat(OP_ARM, 16'h0000);
    send_beat(OP_PULSE, 16'h5A5A);
    send_beat(OP_PULSE, LEADER_MIN_RST);
    send_beat(OP_PULSE, 16'hFFFF);
    send_frame(LEADER_MIN_RST, {8'hFF, 8'h00, 8'h00, 8'hFF}, -1);
    send_beat(OP_READ, 16'h0000);
    send_beat(OP_READ, 16'h0000);
    send_beat(OP_SPARE, 16'h0000);

    for (seg = 0; seg < 6; seg++) begin
      wait_idle();
      case (seg)
        1: set_window(16'h0000, 16'hFFFF, 16'h0000);
        2: begin
          lo = 16'($urandom_range(0, 40000));
          set_window(lo, lo + 16'($urandom_range(0, 20000)), 16'($urandom_range(0, 65535)));
        end
        3: set_window(16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: begin
          write_reg(REG_SPARE, 16'($urandom));
          set_window(LEADER_MIN_RST, LEADER_MAX_RST, ONE_THRESHOLD_RST);
        end
        5: begin
          lo = 16'($urandom_range(30000, 65535));
          set_window(lo, 16'($urandom_range(0, lo - 1)), 16'($urandom_range(0, 65535)));
        end
        default: ;
      endcase
      if (seg < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 65;
      end else if (seg < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 4) hold_request = 400;
      target = counted_beats + SEG_BEATS;
      while (counted_beats < target) random_item();
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
